// File: hw/rtl/vrbs_pkg.sv
// ----------------------------------------------------------------------------
// vrbs_pkg: shared types and codes of the variable record byte stack
//
// Holds the input and result item layouts, the function codes and the
// status codes used by the control, the output stage and the checker.
// ----------------------------------------------------------------------------
package vrbs_pkg;

    // Function codes carried in the func field of an input item.
    localparam logic [2:0] FN_PUSH  = 3'd0;
    localparam logic [2:0] FN_POP   = 3'd1;
    localparam logic [2:0] FN_PEEK  = 3'd2;
    localparam logic [2:0] FN_CLEAR = 3'd3;
    localparam logic [2:0] FN_QUERY = 3'd4;

    // Status codes carried in the status field of a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One input item.
    typedef struct packed {
        logic [2:0] func;
        logic [5:0] record_size;
        logic [7:0] data_byte;
        logic       first_of_record;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [5:0] stored_length;
        logic       is_empty;
        logic       would_be_full;
    } t_out_item;

endpackage

// File: hw/rtl/variable_record_byte_stack.sv
// ----------------------------------------------------------------------------
// variable_record_byte_stack: stack of variable-length byte records
//
// Records grow downward in one byte-wide memory, each with a little-endian
// length header below its data. Push, pop, peek, clear and a full query.
//
//   Channel   Handshake                  Payload     Items
//   input     i_in_valid / o_in_ready    i_in_item   one per function
//   output    o_out_valid / i_out_ready  o_out_item  1 to MAX_RECORD per item
//
// One item at a time. A first push item makes one memory write per header
// byte plus one for the first data byte, or writes only the header for an
// empty record. Pop and peek use the single memory port for a header read
// and then one read per byte sent. Reset (synchronous, active low) empties
// the stack at once; memory contents are not cleared. A stalled output holds
// the sequencer.
// ----------------------------------------------------------------------------
module variable_record_byte_stack #(
    parameter int STACK_BYTES  = 1024,
    parameter int HEADER_BYTES = 4,
    parameter int MAX_RECORD   = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vrbs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vrbs_pkg::t_out_item o_out_item
);
    import vrbs_pkg::*;

    localparam int AW = $clog2(STACK_BYTES);

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;
    logic          out_free;
    logic          out_load;
    t_out_item     out_item;

    // Sequencer.
    vrbs_ctrl #(
        .STACK_BYTES  (STACK_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_RECORD   (MAX_RECORD),
        .AW           (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata),
        .i_out_free  (out_free),
        .o_out_load  (out_load),
        .o_out_item  (out_item)
    );

    // Stack memory.
    vrbs_ram #(
        .DEPTH (STACK_BYTES),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Output register.
    vrbs_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (out_load),
        .i_item      (out_item),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// File: hw/rtl/vrbs_ram.sv
// ----------------------------------------------------------------------------
// vrbs_ram: byte-wide single-port stack memory
//
// One access per cycle, a write or a read; the user keeps to it, the memory
// does not enforce it. Read data is registered and held until the next read.
// ----------------------------------------------------------------------------
module vrbs_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port and registered read port share one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/vrbs_outq.sv
// ----------------------------------------------------------------------------
// vrbs_outq: result output register
//
// Holds one result item for the downstream side, so the control can take
// the next input item while a finished result still waits.
// ----------------------------------------------------------------------------
module vrbs_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  vrbs_pkg::t_out_item i_item,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vrbs_pkg::t_out_item o_out_item
);
    import vrbs_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // The slot is free when empty or when its item leaves in this cycle.
    assign o_free = !r_valid || i_out_ready;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// File: hw/rtl/vrbs_ctrl.sv
// ----------------------------------------------------------------------------
// vrbs_ctrl: stack sequencer
//
// Takes one input item at a time, keeps the stack pointers and the push
// progress, writes headers and data bytes to the memory, reads headers and
// record bytes back, and hands each result item to the output register.
// ----------------------------------------------------------------------------
module vrbs_ctrl #(
    parameter int STACK_BYTES  = 1024,
    parameter int HEADER_BYTES = 4,
    parameter int MAX_RECORD   = 63,
    parameter int AW           = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vrbs_pkg::t_in_item  i_in_item,
    output logic                o_mem_we,
    output logic                o_mem_re,
    output logic [AW-1:0]       o_mem_addr,
    output logic [7:0]          o_mem_wdata,
    input  logic [7:0]          i_mem_rdata,
    input  logic                i_out_free,
    output logic                o_out_load,
    output vrbs_pkg::t_out_item o_out_item
);
    import vrbs_pkg::*;

    // Pointer width holds STACK_BYTES itself; sums get headroom for size+header.
    localparam int TW = $clog2(STACK_BYTES + 1);
    localparam int SW = (TW > 7) ? TW + 1 : 8;
    localparam int CW = $clog2(HEADER_BYTES + 1);
    localparam logic [TW-1:0] TOP_EMPTY = TW'(STACK_BYTES);
    localparam logic [SW-1:0] STACK_S   = SW'(STACK_BYTES);
    localparam logic [SW-1:0] HDR_S     = SW'(HEADER_BYTES);
    localparam logic [CW-1:0] CNT_LAST  = CW'(HEADER_BYTES - 1);
    localparam logic [5:0]    MAX_REC   = 6'(MAX_RECORD);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_HDR   = 4'd2;
    localparam logic [3:0] S_DATA  = 4'd3;
    localparam logic [3:0] S_HWAIT = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_BYTE  = 4'd6;
    localparam logic [3:0] S_RES   = 4'd7;

    logic [3:0]    r_state, n_state;
    t_in_item      r_item, n_item;
    logic [TW-1:0] r_top, n_top;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [5:0]    r_left, n_left;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_status, n_status;
    logic          r_wf, n_wf;
    logic [5:0]    r_stored, n_stored;
    logic [5:0]    r_n, n_n;
    logic [5:0]    r_idx, n_idx;
    logic [TW-1:0] r_base, n_base;

    logic [SW-1:0] need_s;
    logic          too_big;
    logic [TW-1:0] fit_top;
    logic [TW-1:0] fit_wa;
    logic [SW-1:0] top_h;
    logic [SW-1:0] room;
    logic [5:0]    hdr_len;
    logic [5:0]    stored;
    logic [5:0]    emit_n;
    logic [SW-1:0] pop_top;
    logic [TW-1:0] hdr_addr;
    logic [TW-1:0] rd_addr;
    logic [5:0]    left_dec;

    // Free-space test shared by push and query.
    assign need_s  = SW'(r_item.record_size) + HDR_S;
    assign too_big = (r_item.record_size > MAX_REC) || (SW'(r_top) < need_s);
    assign fit_top = r_top - need_s[TW-1:0];
    assign fit_wa  = fit_top + HDR_S[TW-1:0];

    // Header decode: stored length is cut to the bytes above the header.
    assign top_h   = SW'(r_top) + HDR_S;
    assign room    = (top_h <= STACK_S) ? (STACK_S - top_h) : '0;
    assign hdr_len = i_mem_rdata[5:0];
    assign stored  = (SW'(hdr_len) > room) ? room[5:0] : hdr_len;
    assign emit_n  = (r_item.record_size < stored) ? r_item.record_size : stored;
    assign pop_top = top_h + SW'(stored);

    assign hdr_addr = r_top + TW'(r_cnt);
    assign rd_addr  = r_base + TW'(r_idx);
    assign left_dec = r_left - 6'd1;

    assign o_in_ready = (r_state == S_IDLE);

    // Next-state and memory access logic.
    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_top    = r_top;
        n_waddr  = r_waddr;
        n_left   = r_left;
        n_drop   = r_drop;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_wf     = r_wf;
        n_stored = r_stored;
        n_n      = r_n;
        n_idx    = r_idx;
        n_base   = r_base;

        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_addr  = r_waddr;
        o_mem_wdata = r_item.data_byte;
        o_out_load  = 1'b0;

        o_out_item               = '0;
        o_out_item.last          = 1'b1;
        o_out_item.status        = r_status;
        o_out_item.stored_length = r_stored;
        o_out_item.would_be_full = r_wf;
        o_out_item.is_empty      = (r_top >= TOP_EMPTY);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_status = ST_OK;
                n_wf     = 1'b0;
                n_stored = '0;
                n_state  = S_RES;
                case (r_item.func)
                    FN_PUSH: begin
                        if (r_item.first_of_record) begin
                            // A new record ends any pending one.
                            n_left = '0;
                            n_drop = 1'b0;
                            if (too_big) begin
                                n_status = ST_FULL;
                                if (r_item.record_size != 6'd0) begin
                                    n_drop = 1'b1;
                                    n_left = r_item.record_size - 6'd1;
                                end
                            end else begin
                                n_top   = fit_top;
                                n_waddr = fit_wa[AW-1:0];
                                n_cnt   = '0;
                                n_state = S_HDR;
                            end
                        end else if (r_left != 6'd0) begin
                            // Continuation byte: store it or drop it.
                            if (r_drop) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_we = 1'b1;
                                n_waddr  = r_waddr + AW'(1);
                            end
                            n_left = left_dec;
                            if (left_dec == 6'd0) begin
                                n_drop = 1'b0;
                            end
                        end
                    end
                    FN_POP, FN_PEEK: begin
                        n_left = '0;
                        n_drop = 1'b0;
                        if (r_top >= TOP_EMPTY) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_mem_re   = 1'b1;
                            o_mem_addr = r_top[AW-1:0];
                            n_state    = S_HWAIT;
                        end
                    end
                    FN_CLEAR: begin
                        n_left = '0;
                        n_drop = 1'b0;
                        n_top  = TOP_EMPTY;
                    end
                    FN_QUERY: begin
                        n_wf = too_big;
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end

            // Little-endian length header; bytes above the first are zero.
            S_HDR: begin
                o_mem_we    = 1'b1;
                o_mem_addr  = hdr_addr[AW-1:0];
                o_mem_wdata = (r_cnt == '0) ? {2'b00, r_item.record_size} : 8'h00;
                n_cnt       = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = (r_item.record_size != 6'd0) ? S_DATA : S_RES;
                end
            end

            // First data byte travels with the first item of a record.
            S_DATA: begin
                o_mem_we = 1'b1;
                n_waddr  = r_waddr + AW'(1);
                n_left   = r_item.record_size - 6'd1;
                n_state  = S_RES;
            end

            S_HWAIT: begin
                n_stored = stored;
                n_n      = emit_n;
                n_idx    = '0;
                n_base   = top_h[TW-1:0];
                if (r_item.func == FN_POP) begin
                    n_top = pop_top[TW-1:0];
                end
                n_state = (emit_n == 6'd0) ? S_RES : S_RD;
            end

            S_RD: begin
                o_mem_re   = 1'b1;
                o_mem_addr = rd_addr[AW-1:0];
                n_state    = S_BYTE;
            end

            S_BYTE: begin
                o_out_item.status     = ST_OK;
                o_out_item.out_byte   = i_mem_rdata;
                o_out_item.byte_valid = 1'b1;
                o_out_item.last       = (r_idx == r_n - 6'd1);
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    if (r_idx == r_n - 6'd1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 6'd1;
                        n_state = S_RD;
                    end
                end
            end

            S_RES: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= TOP_EMPTY;
            r_waddr <= '0;
            r_left  <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_waddr <= n_waddr;
            r_left  <= n_left;
            r_drop  <= n_drop;
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_wf     <= n_wf;
        r_stored <= n_stored;
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_base   <= n_base;
    end

endmodule

// File: hw/rtl/vrbs_checker.sv
// ----------------------------------------------------------------------------
// vrbs_checker: port-level checks of the record stack
//
// Watches the top-level ports and flags result items whose fields
// contradict each other, plus the one-item-at-a-time input behavior.
// ----------------------------------------------------------------------------
module vrbs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input vrbs_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input vrbs_pkg::t_out_item o_out_item
);
    import vrbs_pkg::*;

    // A stalled result holds steady.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // An accepted item is worked on alone before the next is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    // A result without a record byte is always the only and final one.
    a_nobyte_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.byte_valid |-> o_out_item.last)
        else $error("result without byte is not last");

    // Full or empty status never carries a byte or a length.
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK) |->
            !o_out_item.byte_valid && (o_out_item.stored_length == 6'd0)
            && !o_out_item.would_be_full)
        else $error("error status with payload");

    // A would-be-full query answer is a lone clean result.
    a_query_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.would_be_full |->
            !o_out_item.byte_valid && (o_out_item.stored_length == 6'd0))
        else $error("full answer mixed with record data");

endmodule

bind variable_record_byte_stack vrbs_checker u_vrbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
